@@ design/lbc_pkg.sv @@
// Shared widths, request codes and controller/datapath handshake types for the LED controller.
package lbc_pkg;

  localparam int NUM_LEDS_DEF = 4;

  localparam int REQ_W       = 3;
  localparam int LED_IDX_W   = 4;
  localparam int PERIOD_W    = 32;
  localparam int DRIVE_W     = 4;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  localparam logic [REQ_W-1:0] REQ_SET    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_TOGGLE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_BLINK  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;   // latch an accepted request
    logic apply;      // execute set / toggle / blink / read
    logic tick_inc;   // advance the ms counter, restart the LED walk
    logic walk_step;  // check one LED of the walk
    logic out_load;   // capture the result word
  } lbc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic walk_last;
  } lbc_sts_t;

endpackage

@@ design/lbc_ctrl.sv @@
// Sequencer for the LED controller: request intake, tick walk and result hand-off.
module lbc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  lbc_pkg::lbc_sts_t sts,
  output lbc_pkg::lbc_cmd_t cmd
);
  import lbc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (sts.is_tick) begin
          cmd.tick_inc = 1'b1;
          state_nxt    = ST_WALK;
        end else begin
          cmd.apply = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ design/lbc_dp.sv @@
// Datapath for the LED controller: LED state, blink timing, ms counter and result register.
module lbc_dp #(
  parameter int NUM_LEDS = lbc_pkg::NUM_LEDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [lbc_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [lbc_pkg::REQ_W-1:0]      in_tuser,
  input  lbc_pkg::lbc_cmd_t              cmd,
  output lbc_pkg::lbc_sts_t              sts,
  output logic [lbc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lbc_pkg::*;

  localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  logic [REQ_W-1:0]     req_type_r;
  logic [LED_IDX_W-1:0] led_idx_r;
  logic                 set_val_r;
  logic [PERIOD_W-1:0]  period_r;

  logic [NUM_LEDS-1:0]  led_on_r;
  logic [NUM_LEDS-1:0]  blink_en_r;
  logic [PERIOD_W-1:0]  half_src_r [NUM_LEDS];
  logic [PERIOD_W-1:0]  last_tgl_r [NUM_LEDS];
  logic [PERIOD_W-1:0]  time_r;
  logic [IDX_W-1:0]     walk_r;
  logic                 rd_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic                 idx_ok;
  logic [IDX_W-1:0]     addr;
  logic [PERIOD_W-1:0]  elapsed;
  logic                 due;
  logic [DRIVE_W-1:0]   drive;

  assign idx_ok  = ({1'b0, led_idx_r} < 5'(NUM_LEDS));
  assign addr    = cmd.walk_step ? walk_r : led_idx_r[IDX_W-1:0];
  assign elapsed = time_r - last_tgl_r[addr];
  assign due     = (elapsed >= (half_src_r[addr] >> 1));

  assign sts.is_tick   = (req_type_r == REQ_TICK);
  assign sts.walk_last = (walk_r == IDX_W'(NUM_LEDS - 1));

  // Only LEDs 0..3 fit in the drive field.
  for (genvar k = 0; k < DRIVE_W; k++) begin : g_drive
    if (k < NUM_LEDS) begin : g_on
      assign drive[k] = led_on_r[k];
    end else begin : g_off
      assign drive[k] = 1'b0;
    end
  end

  // Request latch, read flag and result word.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      set_val_r  <= in_tdata[LED_IDX_W];
      period_r   <= in_tdata[LED_IDX_W+1 +: PERIOD_W];
    end
    if (cmd.apply) begin
      rd_r <= (req_type_r == REQ_READ) && idx_ok && led_on_r[addr];
    end else if (cmd.tick_inc) begin
      rd_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_tdata_r <= {(OUT_TDATA_W-DRIVE_W-1)'(0), rd_r, drive};
    end
  end

  // Request type and index stay under reset so status is defined out of reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_type_r <= REQ_SET;
      led_idx_r  <= '0;
    end else if (cmd.load_req) begin
      req_type_r <= in_tuser;
      led_idx_r  <= in_tdata[LED_IDX_W-1:0];
    end
  end

  // LED state, blink timing and ms counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_on_r   <= '0;
      blink_en_r <= '0;
      time_r     <= '0;
      walk_r     <= '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        half_src_r[i] <= '0;
        last_tgl_r[i] <= '0;
      end
    end else begin
      if (cmd.apply && idx_ok) begin
        case (req_type_r)
          REQ_SET: begin
            blink_en_r[addr] <= 1'b0;
            led_on_r[addr]   <= set_val_r;
          end
          REQ_TOGGLE: begin
            blink_en_r[addr] <= 1'b0;
            led_on_r[addr]   <= !led_on_r[addr];
          end
          REQ_BLINK: begin
            blink_en_r[addr] <= 1'b1;
            half_src_r[addr] <= period_r;
            last_tgl_r[addr] <= time_r;
          end
          default: ;
        endcase
      end
      if (cmd.tick_inc) begin
        time_r <= time_r + 1'b1;
        walk_r <= '0;
      end
      if (cmd.walk_step) begin
        walk_r <= walk_r + 1'b1;
        if (blink_en_r[addr] && due) begin
          last_tgl_r[addr] <= time_r;
          led_on_r[addr]   <= !led_on_r[addr];
        end
      end
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

@@ design/led_blink_controller.sv @@
// Top level of the per-LED on/off and blink controller.
//
//   channel | direction | tdata (low bit first)                       | tuser
//   --------+-----------+---------------------------------------------+----------------
//   in_     | slave     | led_index[3:0], set_value, blink_period_ms  | req_type[2:0]
//   out_    | master    | led_drive[3:0], read_state                  | -
//
// A set, toggle, blink, read or unknown request passes through accept, apply and
// result load. A tick passes through accept, tick increment and a walk that checks
// one LED per cycle against the shared subtract/compare before its result load.
// Reset (rst_n low, synchronous) clears all LEDs, blink state and the ms counter.
// A stalled result holds in the output register while the next request is
// taken; only the final load waits for the output register to free up.
module led_blink_controller #(
  parameter int NUM_LEDS = lbc_pkg::NUM_LEDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [3:0] led_index, [4] set_value, [36:5] blink_period_ms, [39:37] zero
  input  logic [lbc_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] req_type
  input  logic [lbc_pkg::REQ_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [3:0] led_drive, [4] read_state, [7:5] zero
  output logic [lbc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lbc_pkg::*;

  lbc_cmd_t cmd;
  lbc_sts_t sts;

  // Sequence each request: intake, apply or tick walk, result hand-off.
  lbc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Hold LED state, blink periods, toggle stamps and the ms counter.
  lbc_dp #(
    .NUM_LEDS (NUM_LEDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the LED on/off and blink controller.
`timescale 1ns / 100ps

module testbench;
  import lbc_pkg::*;

  // One expected result word, split into its fields.
  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               read_bit;
  } led_result_t;

  localparam int LEDS          = NUM_LEDS_DEF;
  localparam int RAND_PER_LOAD = 205;  // random requests in each idling phase
  localparam int DRAIN_CYCLES  = 3 + LEDS + 16;

  // Predicts the drive map and read bit for each accepted request and
  // holds them until the matching result leaves the block.
  class led_scoreboard;
    bit                  lit[LEDS];
    bit                  blinking[LEDS];
    logic [PERIOD_W-1:0] full_period[LEDS];
    logic [PERIOD_W-1:0] stamp[LEDS];
    logic [PERIOD_W-1:0] ms_count;
    led_result_t         expected_q[$];
    int                  errors;

    function new();
      for (int k = 0; k < LEDS; k++) begin
        lit[k]         = 1'b0;
        blinking[k]    = 1'b0;
        full_period[k] = '0;
        stamp[k]       = '0;
      end
      ms_count = '0;
      errors   = 0;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
      errors++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the millisecond counter and flip every blinking LED whose
    // elapsed time has reached half its period.
    function void advance_ms();
      logic [PERIOD_W-1:0] elapsed;
      ms_count = ms_count + 1'b1;
      for (int k = 0; k < LEDS; k++) begin
        elapsed = ms_count - stamp[k];
        if (blinking[k] && elapsed >= (full_period[k] >> 1)) begin
          stamp[k] = ms_count;
          lit[k]   = ~lit[k];
        end
      end
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [LED_IDX_W-1:0] idx,
                               logic val, logic [PERIOD_W-1:0] period);
      led_result_t res;
      bit          in_range;
      in_range     = (idx < LEDS);
      res.read_bit = 1'b0;
      if (kind == REQ_TICK) begin
        advance_ms();
      end else if (in_range) begin
        case (kind)
          REQ_SET: begin
            blinking[idx] = 1'b0;
            lit[idx]      = val;
          end
          REQ_TOGGLE: begin
            blinking[idx] = 1'b0;
            lit[idx]      = ~lit[idx];
          end
          REQ_BLINK: begin
            blinking[idx]    = 1'b1;
            full_period[idx] = period;
            stamp[idx]       = ms_count;
          end
          REQ_READ: begin
            res.read_bit = lit[idx];
          end
          default: ;
        endcase
      end
      res.drive = '0;
      for (int k = 0; k < LEDS && k < DRIVE_W; k++)
        res.drive[k] = lit[k];
      expected_q.push_back(res);
    endfunction

    task check_result(logic [OUT_TDATA_W-1:0] word);
      led_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending", word, 0);
      end else begin
        want = expected_q.pop_front();
        if (word[DRIVE_W-1:0] !== want.drive)
          report_mismatch("led_drive", word[DRIVE_W-1:0], want.drive);
        if (word[DRIVE_W] !== want.read_bit)
          report_mismatch("read_state", word[DRIVE_W], want.read_bit);
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [3:0] led_index, [4] set_value, [36:5] period
  logic [REQ_W-1:0]       in_tuser;   // [2:0] req_type
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [3:0] led_drive, [4] read_state

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  led_scoreboard sb;

  led_blink_controller #(
    .NUM_LEDS(LEDS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs on either handshake.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Offer one request. Call at a rising edge; leave valid high on return so
  // back-to-back requests never lower and raise it in the same step.
  task send_request(logic [REQ_W-1:0] kind, logic [LED_IDX_W-1:0] idx,
                    logic val, logic [PERIOD_W-1:0] period);
    // hold off at random in the idling phases
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, period, val, idx};
    // wait for the accepting edge; in_tready is seen as it was at that edge
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(kind, idx, val, period);
  endtask

  // Draw one random request. Ticks dominate so blinking LEDs keep flipping;
  // most indexes address real LEDs and most periods are short.
  task random_request();
    int unsigned           pick;
    logic [REQ_W-1:0]      kind;
    logic [LED_IDX_W-1:0]  idx;
    logic [PERIOD_W-1:0]   period;
    pick = $urandom_range(99);
    if (pick < 40)      kind = REQ_TICK;
    else if (pick < 54) kind = REQ_SET;
    else if (pick < 66) kind = REQ_TOGGLE;
    else if (pick < 80) kind = REQ_BLINK;
    else if (pick < 95) kind = REQ_READ;
    else                kind = REQ_W'($urandom_range(7));  // noise, unknown codes included
    idx    = ($urandom_range(9) == 0) ? LED_IDX_W'($urandom_range(15))
                                      : LED_IDX_W'($urandom_range(LEDS - 1));
    period = ($urandom_range(7) == 0) ? PERIOD_W'($urandom()) : PERIOD_W'($urandom_range(24));
    send_request(kind, idx, 1'($urandom_range(1)), period);
  endtask

  // Receive side: check each accepted result, then pick the next ready level.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.check_result(out_tdata);
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: basic set/toggle/read, out-of-range index, unknown codes.
    send_request(REQ_READ,   4'd0,  1'b0, 32'd0);
    send_request(REQ_SET,    4'd0,  1'b1, 32'd0);
    send_request(REQ_SET,    4'd3,  1'b1, 32'hFFFF_FFFF);
    send_request(REQ_SET,    4'd2,  1'b0, 32'd0);
    send_request(REQ_TOGGLE, 4'd2,  1'b0, 32'd0);
    send_request(REQ_TOGGLE, 4'd0,  1'b1, 32'd0);
    send_request(REQ_READ,   4'd3,  1'b0, 32'd0);
    send_request(REQ_READ,   4'd15, 1'b1, 32'd0);
    send_request(REQ_SET,    4'd15, 1'b1, 32'd0);
    send_request(REQ_TOGGLE, 4'd4,  1'b0, 32'd0);
    send_request(REQ_BLINK,  4'd7,  1'b0, 32'd2);
    send_request(3'd5,       4'd0,  1'b1, 32'd0);
    send_request(3'd6,       4'd1,  1'b0, 32'd0);
    send_request(3'd7,       4'd2,  1'b1, 32'hFFFF_FFFF);
    // Periods 0 and 1 flip on every tick, period 4 on every second one; the largest never flips here.
    send_request(REQ_BLINK,  4'd0,  1'b0, 32'd0);
    send_request(REQ_BLINK,  4'd1,  1'b0, 32'd1);
    send_request(REQ_BLINK,  4'd2,  1'b0, 32'd4);
    send_request(REQ_BLINK,  4'd3,  1'b1, 32'hFFFF_FFFF);
    repeat (4) send_request(REQ_TICK, 4'd15, 1'b1, 32'hFFFF_FFFF);
    send_request(REQ_READ,   4'd1,  1'b0, 32'd0);
    send_request(REQ_SET,    4'd0,  1'b0, 32'd0);   // stops blinking on LED 0
    send_request(REQ_TOGGLE, 4'd1,  1'b0, 32'd0);   // stops blinking on LED 1

    // Random traffic under each idling load: none, sender gaps,
    // receiver stalls, then both.
    for (int load = 0; load < 4; load++) begin
      case (load)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      repeat (RAND_PER_LOAD) random_request();
    end
    in_tvalid <= 1'b0;

    // Drain outstanding results, then watch a little longer for strays.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch("results never delivered", sb.pending(), 0);

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/lbc_pkg.sv
design/lbc_ctrl.sv
design/lbc_dp.sv
design/led_blink_controller.sv
tb/testbench.sv
